// File: hw/rtl/joystick_direction_debouncer_macros.svh
// assertion macros for the joystick direction debouncer
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef JOYSTICK_DIRECTION_DEBOUNCER_MACROS_SVH
`define JOYSTICK_DIRECTION_DEBOUNCER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, sampled on the rising clock edge outside reset
`define JDD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jdd check failed");

// next-cycle implication, sampled on the rising clock edge outside reset
`define JDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jdd check failed");

`else

`define JDD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define JDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/jdd_pkg.sv
// shared types and constants for the joystick direction debouncer
// no dependencies; imported by jdd_classify, the top level and the testbench
`default_nettype none

package jdd_pkg;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4,
        DIR_MID   = 3'd5
    } dir_t;

    localparam int STICK_W  = 12;
    localparam int THRESH_W = 11;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // product width for the ratio compares
    localparam int PROD_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_NEEDED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_NEEDED = 3'd3;

    localparam logic [THRESH_W-1:0] RST_MOVE_THRESHOLD  = 11'd1800;
    localparam logic [TIME_W-1:0]   RST_REPEAT_INTERVAL = 32'd250000;
    localparam logic [CNT_W-1:0]    RST_STABLE_NEEDED   = 4'd3;
    localparam logic [CNT_W-1:0]    RST_RELEASE_NEEDED  = 4'd5;

endpackage

`default_nettype wire

// File: hw/rtl/jdd_classify.sv
// raw direction classifier: button, threshold, favored up and axis-dominance ratios
// depends on jdd_pkg
`default_nettype none

module jdd_classify
    import jdd_pkg::*;
(
    input  wire logic                       button_pressed,
    input  wire logic signed [STICK_W-1:0]  stick_x,
    input  wire logic signed [STICK_W-1:0]  stick_y,
    input  wire logic [THRESH_W-1:0]        move_threshold,
    output dir_t                            raw_dir
);

    logic [STICK_W-1:0] ax;
    logic [STICK_W-1:0] ay;
    logic [STICK_W-1:0] t_ext;
    logic [PROD_W-1:0]  ax10, ax13, ax17;
    logic [PROD_W-1:0]  ay10, ay17;
    logic [PROD_W-1:0]  t11;
    logic               below;
    logic               up_favored;
    logic               x_over;
    logic               y_over;

    // magnitude of -2048 is 2048, which fits the unsigned 12-bit range
    assign ax    = stick_x[STICK_W-1] ? STICK_W'(-stick_x) : STICK_W'(stick_x);
    assign ay    = stick_y[STICK_W-1] ? STICK_W'(-stick_y) : STICK_W'(stick_y);
    assign t_ext = STICK_W'(move_threshold);

    assign ax10 = PROD_W'(ax) * PROD_W'(10);
    assign ax13 = PROD_W'(ax) * PROD_W'(13);
    assign ax17 = PROD_W'(ax) * PROD_W'(17);
    assign ay10 = PROD_W'(ay) * PROD_W'(10);
    assign ay17 = PROD_W'(ay) * PROD_W'(17);
    assign t11  = PROD_W'(move_threshold) * PROD_W'(11);

    assign below      = (ax < t_ext) && (ay < t_ext);
    assign up_favored = stick_y[STICK_W-1] && (ay10 > t11) && (ay10 > ax13);
    assign x_over     = ax > t_ext;
    assign y_over     = ay > t_ext;

    always_comb begin
        raw_dir = DIR_NONE;
        if (button_pressed) begin
            raw_dir = DIR_MID;
        end else if (below) begin
            raw_dir = DIR_NONE;
        end else if (up_favored) begin
            raw_dir = DIR_UP;
        end else if (ay10 > ax17) begin
            if (y_over) begin
                raw_dir = stick_y[STICK_W-1] ? DIR_UP : DIR_DOWN;
            end
        end else if (ax10 > ay17) begin
            if (x_over) begin
                raw_dir = stick_x[STICK_W-1] ? DIR_LEFT : DIR_RIGHT;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/joystick_direction_debouncer.sv
// joystick direction debouncer, top level
// depends on jdd_pkg, jdd_classify and joystick_direction_debouncer_macros.svh
//
// usage:
//   s_ channel: one poll word per handshake (button, stick x/y, time in us).
//   m_ channel: one result word per poll (report flag and direction, led
//   state and led toggle event).
//   cfg channel: register writes by index (0 threshold, 1 repeat interval, 2 stable
//   count, 3 release count); always ready; user must write only while idle (unenforced).
// timing:
//   a poll word is captured in the input register, then classified and
//   debounced in one pass into the result register, which drives m_valid.
//   one poll per cycle is sustained while m_ready is high; the debounce state
//   update for one poll fits between those two registers.
// stalls:
//   while m_ready is low the result is held; one more poll waits in the
//   input register, then s_ready drops until the result is taken.
// reset:
//   aresetn low clears both registers' valid flags and the debounce state
//   and loads the register defaults (1800, 250000, 3, 5).
`default_nettype none

module joystick_direction_debouncer
    import jdd_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_button_pressed,
    input  wire logic signed [STICK_W-1:0]  s_stick_x,
    input  wire logic signed [STICK_W-1:0]  s_stick_y,
    input  wire logic [TIME_W-1:0]          s_now_us,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_report_valid,
    output logic [2:0]                      m_report_dir,
    output logic                            m_led_active,
    output logic                            m_led_changed,

    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_wdata
);

`include "joystick_direction_debouncer_macros.svh"

    // configuration
    logic [THRESH_W-1:0] move_threshold_reg;
    logic [TIME_W-1:0]   repeat_interval_reg;
    logic [CNT_W-1:0]    stable_needed_reg;
    logic [CNT_W-1:0]    release_needed_reg;

    // input register
    logic                       in_valid_reg;
    logic                       in_button_reg;
    logic signed [STICK_W-1:0]  in_x_reg;
    logic signed [STICK_W-1:0]  in_y_reg;
    logic [TIME_W-1:0]          in_now_reg;

    // debounce state
    dir_t              prev_raw_dir_reg, prev_raw_dir_next;
    logic [CNT_W-1:0]  stable_cnt_reg, stable_cnt_next;
    logic [CNT_W-1:0]  release_cnt_reg, release_cnt_next;
    dir_t              last_reported_reg, last_reported_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic              active_flag_reg, active_flag_next;

    // result register
    logic              out_valid_reg;
    logic              out_report_reg, out_report_next;
    dir_t              out_dir_reg, out_dir_next;
    logic              out_changed_reg, out_changed_next;

    dir_t              raw_dir;
    dir_t              cur_dir;
    logic              advance;
    logic              operating;
    logic              released;
    logic              due;
    logic [TIME_W-1:0] elapsed;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    jdd_classify u_classify (
        .button_pressed (in_button_reg),
        .stick_x        (in_x_reg),
        .stick_y        (in_y_reg),
        .move_threshold (move_threshold_reg),
        .raw_dir        (raw_dir)
    );

    assign elapsed = in_now_reg - last_time_reg;
    assign due     = elapsed > repeat_interval_reg;

    always_comb begin
        prev_raw_dir_next = prev_raw_dir_reg;
        stable_cnt_next   = stable_cnt_reg;
        release_cnt_next  = release_cnt_reg;
        if (raw_dir == prev_raw_dir_reg) begin
            if (stable_cnt_reg < stable_needed_reg) begin
                stable_cnt_next = stable_cnt_reg + CNT_W'(1);
            end
            if (raw_dir == DIR_NONE) begin
                if (release_cnt_reg < release_needed_reg) begin
                    release_cnt_next = release_cnt_reg + CNT_W'(1);
                end
            end else begin
                release_cnt_next = '0;
            end
        end else begin
            if (stable_cnt_reg != '0) begin
                stable_cnt_next = stable_cnt_reg - CNT_W'(1);
            end
            prev_raw_dir_next = raw_dir;
            release_cnt_next  = (raw_dir == DIR_NONE) ? CNT_W'(1) : '0;
        end
    end

    assign cur_dir   = ((stable_cnt_next >= stable_needed_reg) && (raw_dir != DIR_NONE)) ?
                       raw_dir : DIR_NONE;
    assign operating = cur_dir != DIR_NONE;
    assign released  = release_cnt_next >= release_needed_reg;

    always_comb begin
        last_reported_next = last_reported_reg;
        last_time_next     = last_time_reg;
        out_report_next    = 1'b0;
        out_dir_next       = DIR_NONE;
        if (operating) begin
            if ((cur_dir != last_reported_reg) || due) begin
                last_reported_next = cur_dir;
                last_time_next     = in_now_reg;
                out_report_next    = 1'b1;
                out_dir_next       = cur_dir;
            end
        end else if (released) begin
            last_reported_next = DIR_NONE;
        end
    end

    always_comb begin
        active_flag_next = active_flag_reg;
        out_changed_next = 1'b0;
        if (operating && !active_flag_reg) begin
            active_flag_next = 1'b1;
            out_changed_next = 1'b1;
        end else if (!operating && active_flag_reg && released) begin
            active_flag_next = 1'b0;
            out_changed_next = 1'b1;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_threshold_reg  <= RST_MOVE_THRESHOLD;
            repeat_interval_reg <= RST_REPEAT_INTERVAL;
            stable_needed_reg   <= RST_STABLE_NEEDED;
            release_needed_reg  <= RST_RELEASE_NEEDED;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MOVE_THRESHOLD:  move_threshold_reg  <= cfg_wdata[THRESH_W-1:0];
                CFG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_wdata[TIME_W-1:0];
                CFG_STABLE_NEEDED:   stable_needed_reg   <= cfg_wdata[CNT_W-1:0];
                CFG_RELEASE_NEEDED:  release_needed_reg  <= cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_button_reg <= s_button_pressed;
            in_x_reg      <= s_stick_x;
            in_y_reg      <= s_stick_y;
            in_now_reg    <= s_now_us;
        end
    end

    // debounce state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_raw_dir_reg  <= DIR_NONE;
            stable_cnt_reg    <= '0;
            release_cnt_reg   <= '0;
            last_reported_reg <= DIR_NONE;
            last_time_reg     <= '0;
            active_flag_reg   <= 1'b0;
        end else if (advance) begin
            prev_raw_dir_reg  <= prev_raw_dir_next;
            stable_cnt_reg    <= stable_cnt_next;
            release_cnt_reg   <= release_cnt_next;
            last_reported_reg <= last_reported_next;
            last_time_reg     <= last_time_next;
            active_flag_reg   <= active_flag_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_report_reg  <= out_report_next;
            out_dir_reg     <= out_dir_next;
            out_changed_reg <= out_changed_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_report_valid = out_report_reg;
    assign m_report_dir   = out_dir_reg;
    assign m_led_active   = active_flag_reg;
    assign m_led_changed  = out_changed_reg;

    `JDD_ASSERT_IMPLIES(a_report_has_dir, aclk, aresetn,
        m_valid && m_report_valid, out_dir_reg != DIR_NONE)
    `JDD_ASSERT_IMPLIES(a_quiet_dir_none, aclk, aresetn,
        m_valid && !m_report_valid, out_dir_reg == DIR_NONE)
    `JDD_ASSERT_IMPLIES(a_report_led_on, aclk, aresetn,
        m_valid && m_report_valid, m_led_active)
    `JDD_ASSERT_IMPLIES(a_idle_led_no_last, aclk, aresetn,
        !active_flag_reg, last_reported_reg == DIR_NONE)
    `JDD_ASSERT_NEXT(a_state_holds_on_stall, aclk, aresetn,
        !advance, $stable(prev_raw_dir_reg) && $stable(stable_cnt_reg) && $stable(last_time_reg))

endmodule

`default_nettype wire

// File: sim/joystick_direction_debouncer_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for joystick_direction_debouncer: directed and random polls
// with random gaps and stalls, every result word compared with a hand-written expectation or a debounce predictor
// depends on jdd_pkg and the top-level rtl only

module joystick_direction_debouncer_tb;
    import jdd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
    localparam int PHASES      = 9;
    localparam int PHASE_POLLS = 56;
    localparam int MAX_WAIT    = 16;

    typedef struct packed {
        logic       rpt;
        logic [2:0] dir;
        logic       led;
        logic       chg;
    } poll_result_t;

    typedef struct {
        bit           btn;
        int           x;
        int           y;
        logic [31:0]  now;
        bit           typed;
        poll_result_t want;
    } poll_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_button_pressed = 1'b0;
    logic [STICK_W-1:0]    s_stick_x = '0;
    logic [STICK_W-1:0]    s_stick_y = '0;
    logic [TIME_W-1:0]     s_now_us = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_report_valid;
    logic [2:0]            m_report_dir;
    logic                  m_led_active;
    logic                  m_led_changed;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor copy of registers and debounce state
    logic [THRESH_W-1:0] thresh_r;
    logic [TIME_W-1:0]   repeat_r;
    logic [CNT_W-1:0]    stable_r;
    logic [CNT_W-1:0]    release_r;
    dir_t                seen_dir;
    dir_t                shown_dir;
    logic [CNT_W-1:0]    stable_run;
    logic [CNT_W-1:0]    centre_run;
    logic [TIME_W-1:0]   shown_time;
    logic                led_on;

    poll_result_t pending_results[$];
    poll_row_t    script[$];
    int           errors = 0;
    bit           steady = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    joystick_direction_debouncer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_button_pressed (s_button_pressed),
        .s_stick_x        (s_stick_x),
        .s_stick_y        (s_stick_y),
        .s_now_us         (s_now_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_report_valid   (m_report_valid),
        .m_report_dir     (m_report_dir),
        .m_led_active     (m_led_active),
        .m_led_changed    (m_led_changed),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    function automatic dir_t classify_stick(input int x, input int y, input int t);
        int ax;
        int ay;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        if (ax < t && ay < t) return DIR_NONE;
        // favoured up rule
        if (y < 0 && 10 * ay > 11 * t && 10 * ay > 13 * ax) return DIR_UP;
        if (10 * ay > 17 * ax) begin
            if (y < -t) return DIR_UP;
            if (y > t) return DIR_DOWN;
            return DIR_NONE;
        end
        if (10 * ax > 17 * ay) begin
            if (x < -t) return DIR_LEFT;
            if (x > t) return DIR_RIGHT;
            return DIR_NONE;
        end
        return DIR_NONE;
    endfunction

    function automatic poll_result_t predict_poll(input bit btn,
                                                  input logic signed [STICK_W-1:0] sx,
                                                  input logic signed [STICK_W-1:0] sy,
                                                  input logic [TIME_W-1:0] now);
        dir_t              raw;
        dir_t              cur;
        bit                moving;
        bit                settled;
        logic [TIME_W-1:0] elapsed;
        poll_result_t      res;
        raw = btn ? DIR_MID : classify_stick(int'(sx), int'(sy), int'(thresh_r));
        if (raw == seen_dir) begin
            if (stable_run < stable_r) stable_run = stable_run + 4'd1;
            if (raw == DIR_NONE) begin
                if (centre_run < release_r) centre_run = centre_run + 4'd1;
            end else begin
                centre_run = '0;
            end
        end else begin
            if (stable_run > 0) stable_run = stable_run - 4'd1;
            seen_dir = raw;
            centre_run = (raw == DIR_NONE) ? 4'd1 : 4'd0;
        end
        cur = (stable_run >= stable_r && raw != DIR_NONE) ? raw : DIR_NONE;
        moving = (cur != DIR_NONE);
        settled = (centre_run >= release_r);
        res = '0;
        if (moving) begin
            elapsed = now - shown_time;
            if (cur != shown_dir || elapsed > repeat_r) begin
                shown_dir = cur;
                shown_time = now;
                res.rpt = 1'b1;
                res.dir = cur;
            end
        end else if (settled) begin
            shown_dir = DIR_NONE;
        end
        if (moving && !led_on) begin
            led_on = 1'b1;
            res.chg = 1'b1;
        end else if (!moving && led_on && settled) begin
            led_on = 1'b0;
            res.chg = 1'b1;
        end
        res.led = led_on;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic add_row(input bit btn, input int x, input int y, input logic [31:0] now,
                           input bit typed, input logic rpt, input dir_t dir,
                           input logic led, input logic chg);
        poll_row_t row;
        row.btn = btn;
        row.x = x;
        row.y = y;
        row.now = now;
        row.typed = typed;
        row.want = {rpt, dir, led, chg};
        script.push_back(row);
    endtask

    task automatic send_poll(input bit btn, input int x, input int y, input logic [31:0] now,
                             input bit typed, input poll_result_t want);
        int           gap;
        poll_result_t predicted;
        gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_button_pressed <= btn;
        s_stick_x <= x[STICK_W-1:0];
        s_stick_y <= y[STICK_W-1:0];
        s_now_us <= now;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = predict_poll(btn, x[STICK_W-1:0], y[STICK_W-1:0], now);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // lower valid and wait until every result word is back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_wdata <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_MOVE_THRESHOLD:  thresh_r = data[THRESH_W-1:0];
            CFG_REPEAT_INTERVAL: repeat_r = data[TIME_W-1:0];
            CFG_STABLE_NEEDED:   stable_r = data[CNT_W-1:0];
            CFG_RELEASE_NEEDED:  release_r = data[CNT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side
    initial begin
        int           stall;
        poll_result_t want;
        wait (aresetn === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_report_valid !== want.rpt)
                    report_mismatch("report_valid", int'(m_report_valid), int'(want.rpt));
                if (m_report_dir !== want.dir)
                    report_mismatch("report_dir", int'(m_report_dir), int'(want.dir));
                if (m_led_active !== want.led)
                    report_mismatch("led_active", int'(m_led_active), int'(want.led));
                if (m_led_changed !== want.chg)
                    report_mismatch("led_changed", int'(m_led_changed), int'(want.chg));
            end
        end
    end

    // poll and register side
    initial begin
        int                x;
        int                y;
        int                mag;
        int                lim;
        int                pick;
        int                run_left;
        bit                btn;
        bit                noisy;
        dir_t              aim;
        logic [31:0]       clock_us;
        logic [THRESH_W-1:0] new_t;
        logic [TIME_W-1:0] new_rep;
        logic [CNT_W-1:0]  new_stab;
        logic [CNT_W-1:0]  new_rel;

        thresh_r = RST_MOVE_THRESHOLD;
        repeat_r = RST_REPEAT_INTERVAL;
        stable_r = RST_STABLE_NEEDED;
        release_r = RST_RELEASE_NEEDED;
        seen_dir = DIR_NONE;
        shown_dir = DIR_NONE;
        stable_run = '0;
        centre_run = '0;
        shown_time = '0;
        led_on = 1'b0;

        // register defaults; first rows read straight off the debounce rules
        add_row(0, 0, 0, 0, 1, 0, DIR_NONE, 0, 0);
        add_row(1, -2048, -2048, 1000, 1, 0, DIR_NONE, 0, 0);
        add_row(1, 2047, 2047, 2000, 1, 0, DIR_NONE, 0, 0);
        add_row(1, 0, 0, 3000, 1, 0, DIR_NONE, 0, 0);
        add_row(1, -1, 1, 4000, 1, 1, DIR_MID, 1, 1);
        add_row(1, 0, 0, 5000, 1, 0, DIR_NONE, 1, 0);
        add_row(0, 2047, 0, 6000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 2047, 0, 7000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 2047, -500, 8000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 2047, 0, 9000, 0, 0, DIR_NONE, 0, 0);
        // favoured up just past its ratio limits
        add_row(0, 1500, -1981, 10000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 1500, -1981, 11000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 1500, -1981, 12000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 0, 2047, 13000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 0, 2047, 14000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 0, 2047, 15000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 1800, 0, 16000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, -1801, 0, 17000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 1800, 1800, 18000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, -2048, 1000, 20000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, -2048, 1000, 21000, 0, 0, DIR_NONE, 0, 0);
        // time wraps past 2^32
        add_row(0, -2048, -1000, 32'hFFFF_FFF0, 0, 0, DIR_NONE, 0, 0);
        add_row(0, -2048, 0, 32'h0000_0010, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 0, 0, 30000, 0, 0, DIR_NONE, 0, 0);
        add_row(0, 0, 0, 300000, 0, 0, DIR_NONE, 0, 0);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i])
            send_poll(script[i].btn, script[i].x, script[i].y, script[i].now,
                      script[i].typed, script[i].want);

        clock_us = 32'd400000;
        for (int p = 0; p < PHASES; p++) begin
            steady = 1'b0;
            drain_results();
            case (p)
                0: begin new_t = 11'd0;    new_rep = 32'd0;         new_stab = 4'd1;  new_rel = 4'd1;  end
                1: begin new_t = 11'd2047; new_rep = 32'hFFFF_FFFF; new_stab = 4'd15; new_rel = 4'd15; end
                2: begin new_t = 11'd900;  new_rep = 32'd5000;      new_stab = 4'd2;  new_rel = 4'd3;  end
                // zero counts: checks always met
                3: begin new_t = 11'd1800; new_rep = 32'd250000;    new_stab = 4'd0;  new_rel = 4'd0;  end
                default: begin
                    new_t = THRESH_W'($urandom_range(0, 2047));
                    new_rep = $urandom_range(0, 300000);
                    new_stab = CNT_W'($urandom_range(1, 5));
                    new_rel = CNT_W'($urandom_range(1, 6));
                end
            endcase
            // upper data bits are junk and must be masked off
            cfg_write(CFG_MOVE_THRESHOLD, ($urandom() << THRESH_W) | new_t);
            cfg_write(CFG_REPEAT_INTERVAL, new_rep);
            cfg_write(CFG_STABLE_NEEDED, ($urandom() << CNT_W) | new_stab);
            cfg_write(CFG_RELEASE_NEEDED, ($urandom() << CNT_W) | new_rel);
            cfg_write(CFG_NO_REG, $urandom());

            run_left = 0;
            aim = DIR_NONE;
            noisy = 1'b0;
            for (int n = 0; n < PHASE_POLLS; n++) begin
                steady = (n < 12);
                if (n == PHASE_POLLS / 2) drain_results();
                if (run_left == 0) begin
                    pick = $urandom_range(0, 7);
                    noisy = (pick == 7);
                    aim = dir_t'(pick % 6);
                    run_left = $urandom_range(1, 2 + 2 * int'(stable_r));
                end
                run_left--;
                lim = int'(thresh_r);
                mag = lim + $urandom_range(1, 2048 - lim);
                btn = (aim == DIR_MID);
                x = $urandom_range(0, mag / 2);
                if ($urandom_range(0, 1)) x = -x;
                if (noisy || $urandom_range(0, 9) == 0) begin
                    btn = $urandom_range(0, 1);
                    x = $urandom_range(0, 4095) - 2048;
                    y = $urandom_range(0, 4095) - 2048;
                end else begin
                    case (aim)
                        DIR_UP:   y = -mag;
                        DIR_DOWN: y = (mag > 2047) ? 2047 : mag;
                        DIR_LEFT: begin
                            y = x;
                            x = -mag;
                        end
                        DIR_RIGHT: begin
                            y = x;
                            x = (mag > 2047) ? 2047 : mag;
                        end
                        DIR_MID: begin
                            x = $urandom_range(0, 4095) - 2048;
                            y = $urandom_range(0, 4095) - 2048;
                        end
                        default: begin
                            x = (lim > 1) ? $urandom_range(0, 2 * lim - 2) - (lim - 1) : 0;
                            y = (lim > 1) ? $urandom_range(0, 2 * lim - 2) - (lim - 1) : 0;
                        end
                    endcase
                end
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    clock_us = clock_us + $urandom_range(1, 20000);
                else if (pick < 8)
                    clock_us = shown_time + repeat_r + $urandom_range(0, 1);
                else if (pick < 9)
                    clock_us = clock_us + $urandom_range(100000, 400000);
                else
                    clock_us = $urandom();
                send_poll(btn, x, y, clock_us, 1'b0, '0);
            end
        end

        steady = 1'b0;
        drain_results();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("joystick_direction_debouncer_tb: clean");
        else
            $display("joystick_direction_debouncer_tb: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("joystick_direction_debouncer_tb: errors");
        $finish;
    end

endmodule

// File: joystick_direction_debouncer.f
+incdir+hw/rtl
hw/rtl/jdd_pkg.sv
hw/rtl/jdd_classify.sv
hw/rtl/joystick_direction_debouncer.sv
sim/joystick_direction_debouncer_tb.sv
